// ===== src/bbal_pkg.sv =====
// Shared types, constants and codes of the buddy block allocator.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package bbal_pkg;

    // Field widths fixed by the transaction formats
    localparam int SIZE_W  = 27;
    localparam int OFF_W   = 22;
    localparam int ORDER_W = 4;
    localparam int STAT_W  = 3;
    localparam int HDR_W   = 10;
    // Widest minimum-block index: 256 top blocks of order 15
    localparam int IDX_W   = 23;

    // Free map word geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Command queue depth between front and back
    localparam int QDEPTH = 2;

    localparam logic [HDR_W-1:0]  HDR_RESET  = 10'd40;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 27'd100000000;

    // Parameter defaults
    localparam int MAX_ORDER_LEVEL_DEF = 10;
    localparam int TOP_BLOCKS_DEF      = 32;
    localparam int MIN_BLOCK_BYTES_DEF = 128;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIZE  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_NO_MEM    = 3'd3,
        ST_NOT_ALLOC = 3'd4
    } t_status;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] request_size;
        logic [OFF_W-1:0]  free_offset;
    } t_req_item;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [OFF_W-1:0]   block_offset;
        logic [ORDER_W-1:0] block_order;
    } t_rsp_item;

    // Classified command handed from front to back
    typedef struct packed {
        logic               is_free;
        t_status            status;
        logic [ORDER_W-1:0] order;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

endpackage

// ===== src/bbal_front.sv =====
// Front end: accepts requests, checks sizes and offsets, picks the target
// order or minimum-block index. Depends on bbal_pkg.
module bbal_front #(
    parameter int MAX_ORDER_LEVEL = bbal_pkg::MAX_ORDER_LEVEL_DEF,
    parameter int TOP_BLOCKS      = bbal_pkg::TOP_BLOCKS_DEF,
    parameter int MIN_BLOCK_BYTES = bbal_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [bbal_pkg::HDR_W-1:0]     i_hdr,
    input  logic                           i_hold,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  bbal_pkg::t_req_item            i_item,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready,
    output bbal_pkg::t_cmd                 o_cmd
);

    localparam int TOPB_W    = bbal_pkg::SIZE_W + 1;
    localparam int TOP_BYTES = MIN_BLOCK_BYTES << MAX_ORDER_LEVEL;
    localparam int MIN_COUNT = TOP_BLOCKS << MAX_ORDER_LEVEL;
    localparam int CMPW      = bbal_pkg::IDX_W + 1;
    // Reciprocal of the block size, exact for every 22-bit offset
    localparam int DSH       = bbal_pkg::OFF_W + $clog2(MIN_BLOCK_BYTES);
    localparam int RCP_W     = bbal_pkg::OFF_W + 2;
    localparam int PRD_W     = bbal_pkg::OFF_W + RCP_W;
    localparam int BCK_W     = bbal_pkg::OFF_W + $clog2(MIN_BLOCK_BYTES) + 1;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << DSH)
                                         + 64'(MIN_BLOCK_BYTES) - 64'd1)
                                         / 64'(MIN_BLOCK_BYTES));

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_CHK  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate                     r_state, n_state;
    bbal_pkg::t_req_item         r_item, n_item;
    bbal_pkg::t_cmd              r_cmd, n_cmd;
    logic [bbal_pkg::OFF_W-1:0]  r_quot, n_quot;

    logic [TOPB_W-1:0]           top_bytes;
    logic [TOPB_W-1:0]           hdr_ext;
    logic [TOPB_W-1:0]           limit;
    logic [TOPB_W-1:0]           size_ext;
    logic [bbal_pkg::ORDER_W-1:0] tgt_order;
    logic [PRD_W-1:0]            rcp_prod;
    logic [BCK_W-1:0]            back_prod;

    assign o_ready     = (r_state == F_IDLE) && !i_hold;
    assign o_cmd_valid = (r_state == F_PUSH);
    assign o_cmd       = r_cmd;

    // Size checks and target order of an allocation
    always_comb begin
        top_bytes = TOPB_W'(TOP_BYTES);
        hdr_ext   = TOPB_W'(i_hdr);
        limit     = (top_bytes > hdr_ext) ? (top_bytes - hdr_ext) : '0;
        size_ext  = TOPB_W'(i_item.request_size);
        tgt_order = bbal_pkg::ORDER_W'(MAX_ORDER_LEVEL);
        for (int j = MAX_ORDER_LEVEL - 1; j >= 0; j--) begin
            if ((TOPB_W'(MIN_BLOCK_BYTES) << j) >= size_ext) begin
                tgt_order = bbal_pkg::ORDER_W'(j);
            end
        end
    end

    // Block index by reciprocal multiply, then multiply back to check alignment
    always_comb begin
        rcp_prod  = PRD_W'(r_item.free_offset) * PRD_W'(RECIP);
        back_prod = BCK_W'(r_quot) * BCK_W'(MIN_BLOCK_BYTES);
    end

    always_comb begin
        n_state = r_state;
        n_item  = r_item;
        n_cmd   = r_cmd;
        n_quot  = r_quot;
        case (r_state)
            F_IDLE: begin
                if (i_valid && o_ready) begin
                    n_item        = i_item;
                    n_cmd.is_free = i_item.req_type;
                    n_cmd.order   = tgt_order;
                    n_cmd.idx     = '0;
                    if (i_item.req_type == bbal_pkg::REQ_FREE) begin
                        n_state = F_DIV;
                    end else begin
                        if (i_item.request_size == '0 ||
                            i_item.request_size > bbal_pkg::SIZE_LIMIT) begin
                            n_cmd.status = bbal_pkg::ST_BAD_SIZE;
                        end else if (size_ext > limit) begin
                            n_cmd.status = bbal_pkg::ST_TOO_LARGE;
                        end else begin
                            n_cmd.status = bbal_pkg::ST_OK;
                        end
                        n_state = F_PUSH;
                    end
                end
            end
            F_DIV: begin
                n_quot  = bbal_pkg::OFF_W'(rcp_prod >> DSH);
                n_state = F_CHK;
            end
            F_CHK: begin
                n_cmd.idx = bbal_pkg::IDX_W'(r_quot);
                if (back_prod != BCK_W'(r_item.free_offset) ||
                    CMPW'(r_quot) >= CMPW'(MIN_COUNT)) begin
                    n_cmd.status = bbal_pkg::ST_NOT_ALLOC;
                end else begin
                    n_cmd.status = bbal_pkg::ST_OK;
                end
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (i_cmd_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_cmd  <= n_cmd;
        r_quot <= n_quot;
    end

endmodule

// ===== src/bbal_cmd_q.sv =====
// Short command queue between the front end and the allocation engine.
// Depends on bbal_pkg for the command type and depth.
module bbal_cmd_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bbal_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bbal_pkg::t_cmd o_pop_cmd
);

    localparam int PTR_W = $clog2(bbal_pkg::QDEPTH);
    localparam int CNT_W = $clog2(bbal_pkg::QDEPTH + 1);

    bbal_pkg::t_cmd   r_mem [bbal_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != CNT_W'(bbal_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PTR_W'(bbal_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PTR_W'(bbal_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

// ===== src/bbal_back.sv =====
// Allocation engine: free bitmaps, allocation marks and orders in memory,
// word-serial search, split and merge. Depends on bbal_pkg.
module bbal_back #(
    parameter int MAX_ORDER_LEVEL = bbal_pkg::MAX_ORDER_LEVEL_DEF,
    parameter int TOP_BLOCKS      = bbal_pkg::TOP_BLOCKS_DEF,
    parameter int MIN_BLOCK_BYTES = bbal_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    output logic                o_clearing,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  bbal_pkg::t_cmd      i_cmd,
    output logic                o_valid,
    input  logic                i_ready,
    output bbal_pkg::t_rsp_item o_item
);

    localparam int WORD_W    = bbal_pkg::WORD_W;
    localparam int BIT_W     = bbal_pkg::BIT_W;
    localparam int ORD_N     = MAX_ORDER_LEVEL + 1;
    localparam int JW        = $clog2(ORD_N);
    localparam int MIN_COUNT = TOP_BLOCKS << MAX_ORDER_LEVEL;
    localparam int MIDX_W    = $clog2(MIN_COUNT);
    localparam int NWORDS    = (MIN_COUNT + WORD_W - 1) / WORD_W;
    localparam int WIDX_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int ADEPTH    = 1 << WIDX_W;
    localparam int FDEPTH    = ORD_N << WIDX_W;
    localparam int FADDR_W   = $clog2(FDEPTH);
    localparam int CNT_W     = $clog2(MIN_COUNT + 1);
    localparam int PROD_W    = MIDX_W + $clog2(MIN_BLOCK_BYTES + 1);
    localparam int POS_W     = WIDX_W + BIT_W;

    typedef enum logic [17:0] {
        B_CLEAR = 18'h00001,
        B_IDLE  = 18'h00002,
        B_SCHK  = 18'h00004,
        B_SRD   = 18'h00008,
        B_SDAT  = 18'h00010,
        B_SPLT  = 18'h00020,
        B_SPRD  = 18'h00040,
        B_SPWR  = 18'h00080,
        B_MKRD  = 18'h00100,
        B_MKWR  = 18'h00200,
        B_FRD   = 18'h00400,
        B_FCHK  = 18'h00800,
        B_MGCHK = 18'h01000,
        B_MGRD  = 18'h02000,
        B_MGDAT = 18'h04000,
        B_PUTRD = 18'h08000,
        B_PUTWR = 18'h10000,
        B_MUL   = 18'h20000
    } t_bstate;

    // Index of the lowest set bit of a word
    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (w[b]) begin
                pos = BIT_W'(b);
            end
        end
        return pos;
    endfunction

    logic [WORD_W-1:0]          fmem [FDEPTH];
    logic [WORD_W-1:0]          amem [ADEPTH];
    logic [bbal_pkg::ORDER_W-1:0] omem [MIN_COUNT];

    t_bstate                    r_state, n_state;
    logic [JW-1:0]              r_j, n_j;
    logic [JW-1:0]              r_k, n_k;
    logic [MIDX_W-1:0]          r_i, n_i;
    logic [WIDX_W-1:0]          r_w, n_w;
    logic [FADDR_W-1:0]         r_clr;
    logic [CNT_W-1:0]           r_cnt [ORD_N];
    bbal_pkg::t_rsp_item        r_rsp, n_rsp;
    logic                       r_ovalid, n_ovalid;
    logic [WORD_W-1:0]          r_fdata, r_adata;
    logic [bbal_pkg::ORDER_W-1:0] r_odata;

    logic                       f_we, a_we, o_we;
    logic [FADDR_W-1:0]         f_waddr, f_raddr;
    logic [WORD_W-1:0]          f_wdata, a_wdata;
    logic [WIDX_W-1:0]          a_addr;
    logic                       cnt_inc, cnt_dec;

    logic [MIDX_W-1:0]          i_odd, i_bud;
    logic [BIT_W-1:0]           b_self, b_odd, b_bud, b_low;
    logic [WIDX_W-1:0]          w_self, w_odd, w_bud;
    logic [JW-1:0]              clr_ord;
    logic [WIDX_W-1:0]          clr_word;
    logic [WORD_W-1:0]          init_word;
    logic [POS_W-1:0]           init_pos;
    logic [bbal_pkg::ORDER_W-1:0] stored_ord;
    logic [JW-1:0]              free_ord;
    logic [PROD_W-1:0]          prod;

    assign o_clearing  = (r_state == B_CLEAR);
    assign o_cmd_ready = (r_state == B_IDLE) && !r_ovalid;
    assign o_valid     = r_ovalid;
    assign o_item      = r_rsp;

    // Word and bit positions of the current block, its upper half and buddy
    always_comb begin
        i_odd  = r_i | MIDX_W'(1);
        i_bud  = r_i ^ MIDX_W'(1);
        w_self = WIDX_W'(r_i >> BIT_W);
        w_odd  = WIDX_W'(i_odd >> BIT_W);
        w_bud  = WIDX_W'(i_bud >> BIT_W);
        b_self = BIT_W'(r_i);
        b_odd  = BIT_W'(i_odd);
        b_bud  = BIT_W'(i_bud);
        b_low  = low_bit(r_fdata);
        stored_ord = (r_odata > bbal_pkg::ORDER_W'(MAX_ORDER_LEVEL))
                   ? bbal_pkg::ORDER_W'(MAX_ORDER_LEVEL) : r_odata;
        free_ord = JW'(stored_ord);
        prod = PROD_W'(r_i) * PROD_W'(MIN_BLOCK_BYTES);
    end

    // Reset image of one free map word
    always_comb begin
        clr_ord  = JW'(r_clr >> WIDX_W);
        clr_word = WIDX_W'(r_clr);
        init_word = '0;
        for (int b = 0; b < WORD_W; b++) begin
            init_pos = {clr_word, BIT_W'(b)};
            if (clr_ord == JW'(MAX_ORDER_LEVEL) &&
                32'(init_pos) < 32'(TOP_BLOCKS)) begin
                init_word[b] = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_j      = r_j;
        n_k      = r_k;
        n_i      = r_i;
        n_w      = r_w;
        n_rsp    = r_rsp;
        n_ovalid = r_ovalid && !i_ready;
        f_we     = 1'b0;
        f_waddr  = FADDR_W'({r_j, w_self});
        f_wdata  = r_fdata;
        f_raddr  = FADDR_W'({r_j, w_self});
        a_we     = 1'b0;
        a_addr   = w_self;
        a_wdata  = r_adata;
        o_we     = 1'b0;
        cnt_inc  = 1'b0;
        cnt_dec  = 1'b0;
        case (r_state)
            B_CLEAR: begin
                f_we    = 1'b1;
                f_waddr = r_clr;
                f_wdata = init_word;
                a_we    = 1'b1;
                a_addr  = clr_word;
                a_wdata = '0;
                if (r_clr == FADDR_W'(FDEPTH - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_cmd_valid && o_cmd_ready) begin
                    if (i_cmd.status != bbal_pkg::ST_OK) begin
                        n_rsp.status       = i_cmd.status;
                        n_rsp.block_offset = '0;
                        n_rsp.block_order  = '0;
                        n_ovalid           = 1'b1;
                    end else if (i_cmd.is_free) begin
                        n_i     = MIDX_W'(i_cmd.idx);
                        n_state = B_FRD;
                    end else begin
                        n_k     = JW'(i_cmd.order);
                        n_j     = JW'(i_cmd.order);
                        n_state = B_SCHK;
                    end
                end
            end
            // Skip empty orders, scan the first one with a free block
            B_SCHK: begin
                if (r_cnt[r_j] != '0) begin
                    n_w     = '0;
                    n_state = B_SRD;
                end else if (r_j == JW'(MAX_ORDER_LEVEL)) begin
                    n_rsp.status       = bbal_pkg::ST_NO_MEM;
                    n_rsp.block_offset = '0;
                    n_rsp.block_order  = '0;
                    n_ovalid           = 1'b1;
                    n_state            = B_IDLE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            B_SRD: begin
                f_raddr = FADDR_W'({r_j, r_w});
                n_state = B_SDAT;
            end
            B_SDAT: begin
                if (r_fdata != '0) begin
                    f_we    = 1'b1;
                    f_waddr = FADDR_W'({r_j, r_w});
                    f_wdata = r_fdata & ~(WORD_W'(1) << b_low);
                    cnt_dec = 1'b1;
                    n_i     = MIDX_W'({r_w, b_low});
                    n_state = B_SPLT;
                end else begin
                    n_w     = r_w + 1'b1;
                    n_state = B_SRD;
                end
            end
            // Split down, freeing each upper half
            B_SPLT: begin
                if (r_j == r_k) begin
                    n_i     = r_i << r_k;
                    n_state = B_MKRD;
                end else begin
                    n_j     = r_j - 1'b1;
                    n_i     = r_i << 1;
                    n_state = B_SPRD;
                end
            end
            B_SPRD: begin
                f_raddr = FADDR_W'({r_j, w_odd});
                n_state = B_SPWR;
            end
            B_SPWR: begin
                f_we    = 1'b1;
                f_waddr = FADDR_W'({r_j, w_odd});
                f_wdata = r_fdata | (WORD_W'(1) << b_odd);
                cnt_inc = 1'b1;
                n_state = B_SPLT;
            end
            // Record the allocated block start and its order
            B_MKRD: begin
                a_addr  = w_self;
                n_state = B_MKWR;
            end
            B_MKWR: begin
                a_we    = 1'b1;
                a_addr  = w_self;
                a_wdata = r_adata | (WORD_W'(1) << b_self);
                o_we    = 1'b1;
                n_state = B_MUL;
            end
            // Free: check the mark, then merge upward
            B_FRD: begin
                a_addr  = w_self;
                n_state = B_FCHK;
            end
            B_FCHK: begin
                if (!r_adata[b_self]) begin
                    n_rsp.status       = bbal_pkg::ST_NOT_ALLOC;
                    n_rsp.block_offset = '0;
                    n_rsp.block_order  = '0;
                    n_ovalid           = 1'b1;
                    n_state            = B_IDLE;
                end else begin
                    a_we    = 1'b1;
                    a_addr  = w_self;
                    a_wdata = r_adata & ~(WORD_W'(1) << b_self);
                    n_j     = free_ord;
                    n_i     = r_i >> free_ord;
                    n_state = B_MGCHK;
                end
            end
            B_MGCHK: begin
                n_state = (r_j == JW'(MAX_ORDER_LEVEL)) ? B_PUTRD : B_MGRD;
            end
            B_MGRD: begin
                f_raddr = FADDR_W'({r_j, w_bud});
                n_state = B_MGDAT;
            end
            B_MGDAT: begin
                if (r_fdata[b_bud]) begin
                    f_we    = 1'b1;
                    f_waddr = FADDR_W'({r_j, w_bud});
                    f_wdata = r_fdata & ~(WORD_W'(1) << b_bud);
                    cnt_dec = 1'b1;
                    n_i     = r_i >> 1;
                    n_j     = r_j + 1'b1;
                    n_state = B_MGCHK;
                end else begin
                    n_state = B_PUTRD;
                end
            end
            B_PUTRD: begin
                f_raddr = FADDR_W'({r_j, w_self});
                n_state = B_PUTWR;
            end
            B_PUTWR: begin
                f_we    = 1'b1;
                f_waddr = FADDR_W'({r_j, w_self});
                f_wdata = r_fdata | (WORD_W'(1) << b_self);
                cnt_inc = 1'b1;
                n_i     = r_i << r_j;
                n_state = B_MUL;
            end
            // Scale the minimum-block index to a byte offset
            B_MUL: begin
                n_rsp.status       = bbal_pkg::ST_OK;
                n_rsp.block_offset = bbal_pkg::OFF_W'(prod);
                n_rsp.block_order  = bbal_pkg::ORDER_W'(r_j);
                n_ovalid           = 1'b1;
                n_state            = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control state and per-order free counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < ORD_N; k++) begin
                r_cnt[k] <= (k == MAX_ORDER_LEVEL) ? CNT_W'(TOP_BLOCKS) : '0;
            end
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            if (r_state == B_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (cnt_inc) begin
                r_cnt[r_j] <= r_cnt[r_j] + 1'b1;
            end else if (cnt_dec) begin
                r_cnt[r_j] <= r_cnt[r_j] - 1'b1;
            end
        end
        r_j   <= n_j;
        r_k   <= n_k;
        r_i   <= n_i;
        r_w   <= n_w;
        r_rsp <= n_rsp;
    end

    // Free map memory
    always_ff @(posedge i_clk) begin
        if (f_we) begin
            fmem[f_waddr] <= f_wdata;
        end
        r_fdata <= fmem[f_raddr];
    end

    // Allocation mark memory
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            amem[a_addr] <= a_wdata;
        end
        r_adata <= amem[a_addr];
    end

    // Allocated order memory
    always_ff @(posedge i_clk) begin
        if (o_we) begin
            omem[r_i] <= bbal_pkg::ORDER_W'(r_k);
        end
        r_odata <= omem[r_i];
    end

endmodule

// ===== src/buddy_block_allocator_core.sv =====
// Buddy block allocator over TOP_BLOCKS top blocks of MIN_BLOCK_BYTES <<
// MAX_ORDER_LEVEL bytes; one response per request, in order. After reset a
// clearing pass writes every free map word, (MAX_ORDER_LEVEL+1) *
// 2**ceil(log2(TOP_BLOCKS * 2**MAX_ORDER_LEVEL / 32)) of them (11264 at
// defaults), before the first request is taken. A request passes the front
// end; a free also takes a reciprocal multiply for the block index, then a
// multiply back to check alignment. The engine then, for an allocate, skips
// empty orders, scans 32-bit free map words and splits; for a free, it
// merges with free buddies upward.
module buddy_block_allocator_core #(
    parameter int MAX_ORDER_LEVEL = bbal_pkg::MAX_ORDER_LEVEL_DEF,
    parameter int TOP_BLOCKS      = bbal_pkg::TOP_BLOCKS_DEF,
    parameter int MIN_BLOCK_BYTES = bbal_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  bbal_pkg::t_req_item        i_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output bbal_pkg::t_rsp_item        o_item,
    input  logic                       i_cfg_we,
    input  logic [bbal_pkg::HDR_W-1:0] i_cfg_wdata
);

    logic [bbal_pkg::HDR_W-1:0] r_hdr;
    logic                       clearing;
    logic                       fq_valid, fq_ready;
    bbal_pkg::t_cmd             fq_cmd;
    logic                       qb_valid, qb_ready;
    bbal_pkg::t_cmd             qb_cmd;

    // Hold the header size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr <= bbal_pkg::HDR_RESET;
        end else if (i_cfg_we) begin
            r_hdr <= i_cfg_wdata;
        end
    end

    bbal_front #(
        .MAX_ORDER_LEVEL(MAX_ORDER_LEVEL),
        .TOP_BLOCKS     (TOP_BLOCKS),
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hdr      (r_hdr),
        .i_hold     (clearing),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_cmd_valid(fq_valid),
        .i_cmd_ready(fq_ready),
        .o_cmd      (fq_cmd)
    );

    bbal_cmd_q u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(fq_valid),
        .o_push_ready(fq_ready),
        .i_push_cmd  (fq_cmd),
        .o_pop_valid (qb_valid),
        .i_pop_ready (qb_ready),
        .o_pop_cmd   (qb_cmd)
    );

    bbal_back #(
        .MAX_ORDER_LEVEL(MAX_ORDER_LEVEL),
        .TOP_BLOCKS     (TOP_BLOCKS),
        .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_cmd_valid(qb_valid),
        .o_cmd_ready(qb_ready),
        .i_cmd      (qb_cmd),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

// ===== tb/buddy_block_allocator_core_test.sv =====
// Self-checking testbench for buddy_block_allocator_core: directed and random
// alloc/free traffic checked against an in-bench buddy allocator predictor.
// Depends on bbal_pkg and the core RTL only.
module buddy_block_allocator_core_test;

    import bbal_pkg::*;

    localparam int MAX_ORD   = 10;
    localparam int NUM_TOP   = 32;
    localparam int BLK_BYTES = 128;
    localparam int MIN_CNT   = NUM_TOP << MAX_ORD;
    localparam int TOP_BYTES = BLK_BYTES << MAX_ORD;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_valid     = 1'b0;
    logic            o_ready;
    t_req_item       i_item      = '0;
    logic            o_valid;
    logic            i_ready     = 1'b0;
    t_rsp_item       o_item;
    logic            i_cfg_we    = 1'b0;
    logic [HDR_W-1:0] i_cfg_wdata = HDR_RESET;

    buddy_block_allocator_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Allocator image kept by the bench
    bit               free_bits [2*MIN_CNT];
    bit               start_mark [MIN_CNT];
    logic [ORDER_W-1:0] start_order [MIN_CNT];
    int unsigned      hdr_bytes = 40;

    t_rsp_item        rsp_queue [$];
    int unsigned      live_offs [$];
    int unsigned      last_freed = 0;
    int               err_cnt = 0;
    int               burst_left = 0;
    bit               tx_on = 1'b0;
    int               rdy_mode = 0;
    int               rdy_cnt = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int map_base(int k);
        int b;
        b = 0;
        for (int j = 0; j < k; j++) b += NUM_TOP << (MAX_ORD - j);
        return b;
    endfunction

    function automatic t_rsp_item fail_rsp(t_status st);
        t_rsp_item r;
        r = '0;
        r.status = st;
        return r;
    endfunction

    // Allocate: smallest fitting order, lowest free block, split downward
    function automatic t_rsp_item alloc_block(logic [SIZE_W-1:0] sz);
        t_rsp_item r;
        int k, j, i, m;
        bit hit;
        k = 0;
        hit = 0;
        i = 0;
        if (sz == 0 || sz > SIZE_LIMIT) return fail_rsp(ST_BAD_SIZE);
        if (sz > TOP_BYTES - hdr_bytes) return fail_rsp(ST_TOO_LARGE);
        while (k < MAX_ORD && (BLK_BYTES << k) < sz) k++;
        for (j = k; j <= MAX_ORD; j++) begin
            for (i = 0; i < (NUM_TOP << (MAX_ORD - j)); i++) begin
                if (free_bits[map_base(j) + i]) begin
                    hit = 1;
                    break;
                end
            end
            if (hit) break;
        end
        if (!hit) return fail_rsp(ST_NO_MEM);
        free_bits[map_base(j) + i] = 0;
        while (j > k) begin
            j--;
            i = i << 1;
            free_bits[map_base(j) + i + 1] = 1;
        end
        m = i << k;
        start_mark[m] = 1;
        start_order[m] = k;
        r.status = ST_OK;
        r.block_offset = m * BLK_BYTES;
        r.block_order = k;
        return r;
    endfunction

    // Free: return the block and merge with free buddies upward
    function automatic t_rsp_item free_block(logic [OFF_W-1:0] off);
        t_rsp_item r;
        int m, k, i, b;
        if (off % BLK_BYTES != 0) return fail_rsp(ST_NOT_ALLOC);
        m = off / BLK_BYTES;
        if (m >= MIN_CNT || !start_mark[m]) return fail_rsp(ST_NOT_ALLOC);
        k = start_order[m];
        if (k > MAX_ORD) k = MAX_ORD;
        start_mark[m] = 0;
        i = m >> k;
        while (k < MAX_ORD) begin
            b = map_base(k) + (i ^ 1);
            if (!free_bits[b]) break;
            free_bits[b] = 0;
            i = i >> 1;
            k++;
        end
        free_bits[map_base(k) + i] = 1;
        r.status = ST_OK;
        r.block_offset = (i << k) * BLK_BYTES;
        r.block_order = k;
        return r;
    endfunction

    // Drive one request transaction, hold until accepted, then predict
    task automatic send_req(t_req_item it);
        t_rsp_item exp_rsp;
        int idx;
        if (burst_left == 0) begin
            if (tx_on) begin
                i_valid <= 1'b0;
                tx_on = 1'b0;
                @(posedge i_clk);
            end
            repeat ($urandom_range(0, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        tx_on = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        if (it.req_type == REQ_FREE) exp_rsp = free_block(it.free_offset);
        else exp_rsp = alloc_block(it.request_size);
        rsp_queue.push_back(exp_rsp);
        // Track live blocks so random frees hit real allocations
        if (exp_rsp.status == ST_OK) begin
            if (it.req_type == REQ_ALLOC) live_offs.push_back(exp_rsp.block_offset);
            else begin
                last_freed = it.free_offset;
                for (idx = 0; idx < live_offs.size(); idx++) begin
                    if (live_offs[idx] == it.free_offset) begin
                        live_offs.delete(idx);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic do_alloc(int unsigned sz);
        t_req_item it;
        it.req_type = REQ_ALLOC;
        it.request_size = sz;
        it.free_offset = $urandom;
        send_req(it);
    endtask

    task automatic do_free(int unsigned off);
        t_req_item it;
        it.req_type = REQ_FREE;
        it.request_size = $urandom;
        it.free_offset = off;
        send_req(it);
    endtask

    // Drop valid and wait for every expected response, then let the core settle
    task automatic drain();
        if (tx_on) begin
            i_valid <= 1'b0;
            tx_on = 1'b0;
        end
        burst_left = 0;
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_header(int unsigned val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        hdr_bytes = val;
    endtask

    task automatic test_directed();
        do_alloc(1);
        do_alloc(128);
        do_alloc(129);
        do_alloc(TOP_BYTES - 40);
        do_alloc(TOP_BYTES - 39);
        do_alloc(0);
        do_alloc(100000000);
        do_alloc(100000001);
        do_alloc((1 << SIZE_W) - 1);
        do_free(1);
        do_free(4194303);
        do_free(4194176);
        do_free(256);
        do_free(0);
        do_free(0);
        do_free(128);
        do_free(TOP_BYTES);
        do_free(384);
    endtask

    // Fill every top block, overflow twice, then release everything
    task automatic test_exhaustion();
        while (live_offs.size() != 0) do_free(live_offs[0]);
        for (int n = 0; n <= NUM_TOP; n++) do_alloc(TOP_BYTES - hdr_bytes);
        do_alloc(1);
        while (live_offs.size() != 0) do_free(live_offs[$urandom_range(0, live_offs.size()-1)]);
    endtask

    task automatic test_header();
        write_header(0);
        do_alloc(TOP_BYTES);
        do_alloc(TOP_BYTES + 1);
        write_header(1023);
        do_alloc(TOP_BYTES - 1023);
        do_alloc(TOP_BYTES - 1022);
        while (live_offs.size() != 0) do_free(live_offs[0]);
    endtask

    function automatic int unsigned pick_size();
        int r, ord;
        int unsigned sz;
        r = $urandom_range(0, 99);
        ord = r < 40 ? $urandom_range(0, 2) : r < 75 ? $urandom_range(3, 6)
            : r < 95 ? $urandom_range(7, 9) : MAX_ORD;
        if ($urandom_range(0, 4) == 0) sz = BLK_BYTES << ord;
        else sz = $urandom_range(ord == 0 ? 1 : (64 << ord) + 1, BLK_BYTES << ord);
        if (sz > TOP_BYTES - hdr_bytes) sz = TOP_BYTES - hdr_bytes;
        return sz;
    endfunction

    task automatic rand_item();
        int dice, pick;
        dice = $urandom_range(0, 99);
        if (dice < 10) begin
            case ($urandom_range(0, 6))
                0: do_alloc($urandom_range(100000001, (1 << SIZE_W) - 1));
                1: do_alloc(0);
                2: do_alloc($urandom_range(TOP_BYTES - hdr_bytes + 1, 100000000));
                3: do_free(($urandom & 32'h3FFFFF) | $urandom_range(1, 127));
                4: begin
                    if (live_offs.size() != 0)
                        do_free(live_offs[0] + BLK_BYTES * $urandom_range(1, 3));
                    else do_free($urandom & 32'h3FFF80);
                end
                5: do_free($urandom & 32'h3FFF80);
                default: do_free(last_freed);
            endcase
        end else if (live_offs.size() == 0 || dice < (live_offs.size() < 150 ? 60 : 40)) begin
            do_alloc(pick_size());
        end else begin
            pick = $urandom_range(0, live_offs.size() - 1);
            do_free(live_offs[pick]);
        end
    endtask

    task automatic test_random();
        int unsigned hdr_set [4];
        hdr_set = '{1023, 0, 0, 40};
        hdr_set[2] = $urandom_range(1, 1022);
        for (int ph = 0; ph < 4; ph++) begin
            write_header(hdr_set[ph]);
            repeat (260) rand_item();
        end
    endtask

    // Receiver stall pattern: ready always, half or a quarter of the time, mode picked at random
    always @(posedge i_clk) begin
        rdy_cnt <= rdy_cnt + 1;
        if (rdy_cnt % 97 == 0) rdy_mode <= $urandom_range(0, 2);
        case (rdy_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Compare each response transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp_item exp_rsp;
        if (i_rst_n && o_valid && i_ready) begin
            if (rsp_queue.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_item);
                err_cnt++;
            end else begin
                exp_rsp = rsp_queue.pop_front();
                if (o_item.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_rsp.status, o_item.status);
                    err_cnt++;
                end
                if (o_item.block_offset !== exp_rsp.block_offset) begin
                    $display("%0t: block_offset expected %0d actual %0d",
                             $time, exp_rsp.block_offset, o_item.block_offset);
                    err_cnt++;
                end
                if (o_item.block_order !== exp_rsp.block_order) begin
                    $display("%0t: block_order expected %0d actual %0d",
                             $time, exp_rsp.block_order, o_item.block_order);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        for (int n = 0; n < NUM_TOP; n++) free_bits[map_base(MAX_ORD) + n] = 1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_exhaustion();
        test_header();
        test_random();
        write_header(40);
        test_directed();
        drain();
        if (err_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
